@@ sv/kat_pkg.sv @@
`timescale 1ns / 1ps

package kat_pkg;

  // One request as it arrives on the input channel.
  typedef struct packed {
    logic               mode;
    logic        [30:0] item_key;
    logic signed [15:0] add_count;
    logic        [23:0] unit_price;
  } kat_in_t;

  // One result as it leaves on the output channel.
  typedef struct packed {
    logic        [2:0]  status;
    logic        [3:0]  slot;
    logic        [23:0] found_price;
    logic signed [31:0] found_count;
  } kat_out_t;

  typedef enum logic {
    OP_ADD    = 1'b0,
    OP_LOOKUP = 1'b1
  } kat_op_e;

  // A classified request as it waits between the front and the engine.
  typedef struct packed {
    kat_op_e            op;
    logic        [30:0] key;
    logic signed [15:0] cnt;
    logic        [23:0] price;
  } kat_job_t;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_UPDATED   = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_FOUND     = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;

  localparam logic signed [31:0] CNT_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] CNT_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {
    ES_IDLE,
    ES_DECIDE,
    ES_SCAN,
    ES_EMIT
  } kat_eng_state_e;

endpackage

@@ sv/kat_front.sv @@
`timescale 1ns / 1ps

module kat_front
  import kat_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  output logic     full,
  input  kat_in_t  req_i,
  output logic     job_valid_o,
  output kat_job_t job_o,
  input  logic     job_pop_i
);

  kat_job_t   slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  logic       do_push, do_pop;
  kat_job_t   job_in;

  // Decode the request into its operation before it is queued.
  always_comb begin
    job_in.op    = req_i.mode ? OP_LOOKUP : OP_ADD;
    job_in.key   = req_i.item_key;
    job_in.cnt   = req_i.add_count;
    job_in.price = req_i.unit_price;
  end

  assign full        = (fill_q == 2'd2);
  assign do_push     = push && !full;
  assign job_valid_o = (fill_q != 2'd0);
  assign do_pop      = job_pop_i && job_valid_o;
  assign job_o       = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    fill_d   = fill_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= job_in;
    end
  end

endmodule

@@ sv/kat_result_queue.sv @@
`timescale 1ns / 1ps

module kat_result_queue
  import kat_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     res_push_i,
  input  kat_out_t res_i,
  output logic     res_full_o,
  output logic     empty,
  input  logic     pop,
  output kat_out_t rsp_o
);

  kat_out_t   slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  logic       do_push, do_pop;

  assign res_full_o = (fill_q == 2'd2);
  assign empty      = (fill_q == 2'd0);
  assign do_push    = res_push_i && !res_full_o;
  assign do_pop     = pop && !empty;
  assign rsp_o      = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    fill_d   = fill_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= res_i;
    end
  end

endmodule

@@ sv/kat_engine.sv @@
`timescale 1ns / 1ps

module kat_engine
  import kat_pkg::*;
#(
  parameter int unsigned ENTRIES = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     job_valid_i,
  input  kat_job_t job_i,
  output logic     job_pop_o,
  output logic     res_push_o,
  output kat_out_t res_o,
  input  logic     res_full_i
);

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned FW = $clog2(ENTRIES + 1);

  logic        [30:0] key_mem   [ENTRIES];
  logic        [23:0] price_mem [ENTRIES];
  logic signed [31:0] count_mem [ENTRIES];

  logic        [30:0] key_rd_q;
  logic        [23:0] price_rd_q;
  logic signed [31:0] count_rd_q;

  kat_eng_state_e state_q, state_d;
  kat_job_t       job_q, job_d;
  kat_out_t       res_q, res_d;
  logic [FW-1:0]  fill_q, fill_d;
  logic [IW-1:0]  cmp_idx_q, cmp_idx_d;

  logic               rd_en;
  logic [IW-1:0]      rd_addr;
  logic               wr_all_en;
  logic               wr_cnt_en;
  logic [IW-1:0]      wr_addr;
  logic signed [31:0] wr_cnt;

  logic signed [32:0] sum_wide;
  logic signed [31:0] sum_sat;
  logic               last_filled;

  // Saturating accumulation of the stored count.
  always_comb begin
    sum_wide = {count_rd_q[31], count_rd_q} + 33'(job_q.cnt);
    if (sum_wide[32] != sum_wide[31]) begin
      sum_sat = sum_wide[32] ? CNT_MIN : CNT_MAX;
    end else begin
      sum_sat = sum_wide[31:0];
    end
  end

  assign last_filled = (FW'(cmp_idx_q) + FW'(1) == fill_q);
  assign res_o       = res_q;

  always_comb begin
    state_d    = state_q;
    job_d      = job_q;
    res_d      = res_q;
    fill_d     = fill_q;
    cmp_idx_d  = cmp_idx_q;
    job_pop_o  = 1'b0;
    res_push_o = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_all_en  = 1'b0;
    wr_cnt_en  = 1'b0;
    wr_addr    = '0;
    wr_cnt     = '0;

    unique case (state_q)
      ES_IDLE: begin
        if (job_valid_i) begin
          job_d     = job_i;
          job_pop_o = 1'b1;
          if (fill_q == '0) begin
            state_d = ES_DECIDE;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = '0;
            cmp_idx_d = '0;
            state_d   = ES_SCAN;
          end
        end
      end

      ES_DECIDE, ES_SCAN: begin
        if ((state_q == ES_SCAN) && (key_rd_q == job_q.key)) begin
          res_d.slot        = 4'(cmp_idx_q);
          res_d.found_price = price_rd_q;
          if (job_q.op == OP_LOOKUP) begin
            res_d.status      = ST_FOUND;
            res_d.found_count = count_rd_q;
          end else begin
            res_d.status      = ST_UPDATED;
            res_d.found_count = sum_sat;
            wr_cnt_en         = 1'b1;
            wr_addr           = cmp_idx_q;
            wr_cnt            = sum_sat;
          end
          state_d = ES_EMIT;
        end else if ((state_q == ES_DECIDE) || last_filled) begin
          // Miss over all filled entries.
          res_d = '0;
          if (job_q.op == OP_LOOKUP) begin
            res_d.status = ST_NOT_FOUND;
          end else if (fill_q == FW'(ENTRIES)) begin
            res_d.status = ST_FULL;
          end else begin
            res_d.status      = ST_INSERTED;
            res_d.slot        = 4'(fill_q);
            res_d.found_price = job_q.price;
            res_d.found_count = 32'(job_q.cnt);
            wr_all_en         = 1'b1;
            wr_addr           = fill_q[IW-1:0];
            wr_cnt            = 32'(job_q.cnt);
            fill_d            = fill_q + FW'(1);
          end
          state_d = ES_EMIT;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = cmp_idx_q + IW'(1);
          cmp_idx_d = cmp_idx_q + IW'(1);
        end
      end

      ES_EMIT: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          state_d    = ES_IDLE;
        end
      end

      default: begin
        state_d = ES_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ES_IDLE;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q     <= job_d;
    res_q     <= res_d;
    cmp_idx_q <= cmp_idx_d;
  end

  // Table storage: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_all_en) begin
      key_mem[wr_addr]   <= job_q.key;
      price_mem[wr_addr] <= job_q.price;
    end
    if (wr_all_en || wr_cnt_en) begin
      count_mem[wr_addr] <= wr_cnt;
    end
    if (rd_en) begin
      key_rd_q   <= key_mem[rd_addr];
      price_rd_q <= price_mem[rd_addr];
      count_rd_q <= count_mem[rd_addr];
    end
  end

endmodule

@@ sv/keyed_accumulate_table_core.sv @@
`timescale 1ns / 1ps
// Keyed insert-or-accumulate table of ENTRIES entries (key, price, count).
// Requests arrive on a queue-like input: a transfer happens on a rising edge
// with push high and full low. Results leave on a queue-like output: the
// oldest result sits on rsp_o while empty is low, and is taken on an edge
// with pop high and empty low. Every request yields exactly one result.
// An add request accumulates into a matching entry (saturating) or appends a
// new one, or reports full when all entries are taken; a lookup returns the
// stored price and count of the first match. Timing: the engine scans the
// filled entries one per cycle through the registered read port of the table
// memory; a miss is decided once every filled entry is compared, a hit as soon
// as the matching index is read. The engine works on one request at a time and
// pops the next only after the result of the last has gone to the result queue.
// A two-entry request queue in front lets the engine run while new requests
// arrive; a two-entry result queue behind it lets the engine finish while the
// receiver stalls. Once the request queue holds two, full rises and input stalls.
// Reset empties both queues and sets the fill level to zero; the table
// contents need no clearing because only filled entries are ever read.
module keyed_accumulate_table_core
  import kat_pkg::*;
#(
  parameter int unsigned ENTRIES = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  output logic     full,
  input  kat_in_t  req_i,
  output logic     empty,
  input  logic     pop,
  output kat_out_t rsp_o
);

  logic     job_valid;
  kat_job_t job;
  logic     job_pop;
  logic     res_push;
  kat_out_t res;
  logic     res_full;

  // Front: accepts and decodes requests into a short queue.
  kat_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .req_i       (req_i),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_pop_i   (job_pop)
  );

  // Back: scans the table, updates it and forms the result.
  kat_engine #(
    .ENTRIES (ENTRIES)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_pop_o   (job_pop),
    .res_push_o  (res_push),
    .res_o       (res),
    .res_full_i  (res_full)
  );

  // Results wait here until the receiver takes them.
  kat_result_queue u_result_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_push_i (res_push),
    .res_i      (res),
    .res_full_o (res_full),
    .empty      (empty),
    .pop        (pop),
    .rsp_o      (rsp_o)
  );

endmodule
